// ----- src/sepw_pkg.sv -----
// Shared types and constants of the stereo EQ, pan and width mixer.
// Used by the controller, the datapath and the top level.
`default_nettype none

package sepw_pkg;

  localparam int GAIN_RAMP_STEPS_DEF  = 2400;
  localparam int WIDTH_RAMP_STEPS_DEF = 960;
  localparam int SAMPLE_BITS_DEF      = 24;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int STEPS_W    = 12;
  localparam int DIV_W      = 26;

  localparam logic [CFG_IDX_W-1:0] REG_B0       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_B1       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B2       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_A1       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_A2       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PAN_MODE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PAN_L    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PAN_R    = 3'd7;

  localparam logic signed [31:0] B0_RESET     = 32'sd134217728;
  localparam logic [16:0]        PAN_RESET    = 17'd46341;
  localparam logic [24:0]        UNITY_GAIN   = 25'd1048576;

  typedef enum logic [3:0] {
    ST_IDLE, ST_TGT_G, ST_DIV_G, ST_TGT_W, ST_DIV_W,
    ST_MUL, ST_ACC, ST_ADV, ST_DONE
  } ctrl_state_t;

  typedef enum logic [3:0] {
    OP_F0, OP_F1, OP_F2, OP_F3, OP_F4, OP_MA, OP_MB, OP_MC, OP_MD
  } op_t;

  typedef struct packed {
    logic capture;
    logic take_g;
    logic take_w;
    logic div_start;
    logic div_width;
    logic inc_g_load;
    logic inc_w_load;
    logic mul;
    logic acc;
    logic adv;
    logic load_out;
    op_t  op;
    logic chan;
  } cmd_t;

  typedef struct packed {
    logic gain_div;
    logic width_div;
    logic div_done;
    logic pan_mode;
  } stat_t;

  function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = (64'sd1 <<< 47) - 64'sd1;
    lo = -hi - 64'sd1;
    if (v > hi) begin
      return hi[47:0];
    end else if (v < lo) begin
      return lo[47:0];
    end
    return v[47:0];
  endfunction

endpackage

`default_nettype wire

// ----- src/stereo_eq_pan_width_mixer.sv -----
// Stereo biquad EQ with mid-side width or constant-power pan and ramped gain.
// One stereo pair at a time runs through a single shared multiplier: ten filter
// products, then three (width mode) or four (pan mode) mix products. A gain or
// width target that differs from the current goal adds a run of the reciprocal
// ramp-increment divider for each.
// The result sits in an output register; a new pair is taken once it is loaded.
// Depends on sepw_pkg, sepw_ctrl, sepw_dp and sepw_div.
`default_nettype none

module stereo_eq_pan_width_mixer #(
  parameter int GAIN_RAMP_STEPS  = sepw_pkg::GAIN_RAMP_STEPS_DEF,
  parameter int WIDTH_RAMP_STEPS = sepw_pkg::WIDTH_RAMP_STEPS_DEF,
  parameter int SAMPLE_BITS      = sepw_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [sepw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [sepw_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic signed [SAMPLE_BITS-1:0]   in_left_in,
  input  wire logic signed [SAMPLE_BITS-1:0]   in_right_in,
  input  wire logic [23:0]                     in_target_gain,
  input  wire logic [16:0]                     in_target_width,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic signed [SAMPLE_BITS-1:0]        out_left_out,
  output logic signed [SAMPLE_BITS-1:0]        out_right_out
);
  import sepw_pkg::*;

  cmd_t  cmd;
  stat_t st;

  sepw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  sepw_dp #(
    .GAIN_RAMP_STEPS  (GAIN_RAMP_STEPS),
    .WIDTH_RAMP_STEPS (WIDTH_RAMP_STEPS),
    .SAMPLE_BITS      (SAMPLE_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_left_in      (in_left_in),
    .in_right_in     (in_right_in),
    .in_target_gain  (in_target_gain),
    .in_target_width (in_target_width),
    .out_left_out    (out_left_out),
    .out_right_out   (out_right_out),
    .cmd             (cmd),
    .st              (st)
  );

  // a transfer in makes the block busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken twice without processing");

  // never overwrite a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !(out_valid && out_stall))
    else $error("pending result overwritten");

  // every product is consumed on the following cycle
  a_mul_then_acc: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul |=> (cmd.acc && $stable(cmd.op)))
    else $error("product not consumed");

endmodule

`default_nettype wire

// ----- src/sepw_div.sv -----
// Ramp-increment divider by a constant step count, truncating toward zero.
// Registers the magnitude, then its reciprocal product; no package dependency.
`default_nettype none

module sepw_div #(
  parameter int DIVISOR = 1,
  parameter int NUM_W   = 25
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic signed [NUM_W:0] dividend,
  output logic signed [NUM_W:0]      quot,
  output logic                       done
);

  localparam int     DIV_SAFE = (DIVISOR < 1) ? 1 : DIVISOR;
  localparam int     SHIFT    = NUM_W + $clog2(DIV_SAFE);
  // rounded-up reciprocal; exact for every magnitude below 2**NUM_W
  localparam longint RECIP    = ((longint'(1) <<< SHIFT) + longint'(DIV_SAFE) - 1)
                                / longint'(DIV_SAFE);
  localparam logic [NUM_W:0] RECIP_C = RECIP[NUM_W:0];

  logic               stage1_r;
  logic               stage2_r;
  logic [NUM_W-1:0]   mag_r;
  logic               neg_r;
  logic [2*NUM_W:0]   prod_r;
  logic [NUM_W-1:0]   mag_in;
  logic [NUM_W-1:0]   q;

  assign mag_in = dividend[NUM_W] ? NUM_W'(-dividend) : NUM_W'(dividend);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage1_r <= 1'b0;
      stage2_r <= 1'b0;
    end else begin
      stage1_r <= start;
      stage2_r <= stage1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mag_r <= mag_in;
      neg_r <= dividend[NUM_W];
    end
    if (stage1_r) begin
      prod_r <= mag_r * RECIP_C;
    end
  end

  assign q    = NUM_W'(prod_r >> SHIFT);
  assign quot = neg_r ? -$signed({1'b0, q}) : $signed({1'b0, q});
  assign done = stage2_r;

endmodule

`default_nettype wire

// ----- src/sepw_ctrl.sv -----
// Sequencer of the mixer: target intake, ramp divisions, multiply schedule, output.
// Depends on sepw_pkg for the state, operation, command and status types.
`default_nettype none

module sepw_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  wire logic            out_stall,
  input  wire sepw_pkg::stat_t st,
  output sepw_pkg::cmd_t       cmd
);
  import sepw_pkg::*;

  ctrl_state_t state_r, state_nxt;
  op_t         op_r, op_nxt;
  logic        chan_r, chan_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        can_load;

  assign can_load  = !out_valid_r || !out_stall;
  assign in_stall  = state_r != ST_IDLE;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_F0;
      chan_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      chan_r      <= chan_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state and schedule position
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    chan_nxt  = chan_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_TGT_G;
        end
      end
      ST_TGT_G: state_nxt = st.gain_div ? ST_DIV_G : ST_TGT_W;
      ST_DIV_G: begin
        if (st.div_done) begin
          state_nxt = ST_TGT_W;
        end
      end
      ST_TGT_W: begin
        state_nxt = st.width_div ? ST_DIV_W : ST_MUL;
        op_nxt    = OP_F0;
        chan_nxt  = 1'b0;
      end
      ST_DIV_W: begin
        if (st.div_done) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: state_nxt = ST_ACC;
      ST_ACC: begin
        state_nxt = ST_MUL;
        case (op_r)
          OP_F0: op_nxt = OP_F1;
          OP_F1: op_nxt = OP_F2;
          OP_F2: op_nxt = OP_F3;
          OP_F3: op_nxt = OP_F4;
          OP_F4: begin
            op_nxt = OP_F0;
            if (chan_r) begin
              state_nxt = ST_ADV;
            end else begin
              chan_nxt = 1'b1;
            end
          end
          OP_MA: op_nxt = OP_MB;
          OP_MB: op_nxt = OP_MC;
          OP_MC: begin
            if (st.pan_mode) begin
              op_nxt = OP_MD;
            end else begin
              state_nxt = ST_DONE;
            end
          end
          OP_MD: state_nxt = ST_DONE;
          default: state_nxt = ST_DONE;
        endcase
      end
      ST_ADV: begin
        state_nxt = ST_MUL;
        op_nxt    = OP_MA;
      end
      ST_DONE: begin
        if (can_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // commands to the datapath
  always_comb begin
    cmd           = '0;
    cmd.op        = op_r;
    cmd.chan      = chan_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_IDLE:  cmd.capture = in_valid;
      ST_TGT_G: begin
        cmd.take_g    = 1'b1;
        cmd.div_start = st.gain_div;
      end
      ST_DIV_G: cmd.inc_g_load = st.div_done;
      ST_TGT_W: begin
        cmd.take_w    = 1'b1;
        cmd.div_width = 1'b1;
        cmd.div_start = st.width_div;
      end
      ST_DIV_W: cmd.inc_w_load = st.div_done;
      ST_MUL:   cmd.mul = 1'b1;
      ST_ACC:   cmd.acc = 1'b1;
      ST_ADV:   cmd.adv = 1'b1;
      ST_DONE: begin
        if (can_load) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- src/sepw_dp.sv -----
// Datapath of the mixer: registers, ramps, biquad state, shared multiplier.
// Depends on sepw_pkg and sepw_div.
`default_nettype none

module sepw_dp #(
  parameter int GAIN_RAMP_STEPS  = sepw_pkg::GAIN_RAMP_STEPS_DEF,
  parameter int WIDTH_RAMP_STEPS = sepw_pkg::WIDTH_RAMP_STEPS_DEF,
  parameter int SAMPLE_BITS      = sepw_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [sepw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [sepw_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  wire logic signed [SAMPLE_BITS-1:0]      in_left_in,
  input  wire logic signed [SAMPLE_BITS-1:0]      in_right_in,
  input  wire logic [23:0]                        in_target_gain,
  input  wire logic [16:0]                        in_target_width,
  output logic signed [SAMPLE_BITS-1:0]           out_left_out,
  output logic signed [SAMPLE_BITS-1:0]           out_right_out,
  input  wire sepw_pkg::cmd_t                     cmd,
  output sepw_pkg::stat_t                         st
);
  import sepw_pkg::*;

  localparam logic signed [63:0] S_HI = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
  localparam logic signed [63:0] S_LO = -S_HI - 64'sd1;

  function automatic logic signed [SAMPLE_BITS-1:0] sat_s(input logic signed [63:0] v);
    if (v > S_HI) begin
      return S_HI[SAMPLE_BITS-1:0];
    end else if (v < S_LO) begin
      return S_LO[SAMPLE_BITS-1:0];
    end
    return v[SAMPLE_BITS-1:0];
  endfunction

  logic signed [31:0] b0_r, b1_r, b2_r, a1_r, a2_r;
  logic               pan_mode_r;
  logic [16:0]        pgl_r, pgr_r;

  logic signed [SAMPLE_BITS-1:0] xl_r, xr_r;
  logic [23:0]        tg_r;
  logic [16:0]        tw_r;

  logic signed [47:0] d0l_r, d1l_r, d0r_r, d1r_r;
  logic signed [30:0] yl_r, yr_r;
  logic signed [63:0] s_r;
  logic signed [35:0] t_r, u_r;
  logic signed [SAMPLE_BITS-1:0] lo_r, ro_r, out_l_r, out_r_r;
  logic signed [68:0] p_r;

  logic [24:0]        gain_now_r, gain_goal_r;
  logic signed [25:0] gain_inc_r;
  logic [11:0]        gain_left_r;
  logic [16:0]        width_now_r, width_goal_r;
  logic signed [17:0] width_inc_r;
  logic [11:0]        width_left_r;

  logic signed [31:0] ysum, ydif;
  logic signed [30:0] mid, side;
  logic signed [SAMPLE_BITS-1:0] x_c;
  logic signed [30:0] y_c;
  logic signed [47:0] d0_c, d1_c, z;
  logic signed [35:0] a_op;
  logic signed [32:0] b_op;
  logic signed [63:0] ph10, ph15, ph16, ph20;
  logic signed [26:0] g_sum;
  logic signed [18:0] w_sum;
  logic               gain_new, width_new;
  logic signed [DIV_W-1:0] gdiv_dividend, gdiv_quot;
  logic signed [17:0] wdiv_dividend, wdiv_quot;
  logic               gdiv_done, wdiv_done;

  assign ysum = {yl_r[30], yl_r} + {yr_r[30], yr_r};
  assign ydif = {yl_r[30], yl_r} - {yr_r[30], yr_r};
  assign mid  = ysum[31:1];
  assign side = ydif[31:1];
  assign x_c  = cmd.chan ? xr_r : xl_r;
  assign y_c  = cmd.chan ? yr_r : yl_r;
  assign d0_c = cmd.chan ? d0r_r : d0l_r;
  assign d1_c = cmd.chan ? d1r_r : d1l_r;

  assign ph10 = 64'(p_r >>> 10);
  assign ph15 = 64'(p_r >>> 15);
  assign ph16 = 64'(p_r >>> 16);
  assign ph20 = 64'(p_r >>> 20);
  assign z    = sat48(ph10 + 64'(d0_c));

  assign gain_new  = {1'b0, tg_r} != gain_goal_r;
  assign width_new = tw_r != width_goal_r;
  assign st.gain_div  = gain_new && (GAIN_RAMP_STEPS != 0);
  assign st.width_div = width_new && (WIDTH_RAMP_STEPS != 0);
  assign st.div_done  = gdiv_done || wdiv_done;
  assign st.pan_mode  = pan_mode_r;

  assign gdiv_dividend = $signed({2'b0, tg_r}) - $signed({1'b0, gain_now_r});
  assign wdiv_dividend = $signed({1'b0, tw_r}) - $signed({1'b0, width_now_r});

  sepw_div #(
    .DIVISOR (GAIN_RAMP_STEPS),
    .NUM_W   (DIV_W - 1)
  ) u_gain_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start && !cmd.div_width),
    .dividend (gdiv_dividend),
    .quot     (gdiv_quot),
    .done     (gdiv_done)
  );

  sepw_div #(
    .DIVISOR (WIDTH_RAMP_STEPS),
    .NUM_W   (17)
  ) u_width_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start && cmd.div_width),
    .dividend (wdiv_dividend),
    .quot     (wdiv_quot),
    .done     (wdiv_done)
  );

  // multiplier operand select
  always_comb begin
    a_op = '0;
    b_op = '0;
    case (cmd.op)
      OP_F0: begin a_op = 36'(b0_r); b_op = 33'(x_c); end
      OP_F1: begin a_op = 36'(b1_r); b_op = 33'(x_c); end
      OP_F2: begin a_op = 36'(a1_r); b_op = 33'(y_c); end
      OP_F3: begin a_op = 36'(b2_r); b_op = 33'(x_c); end
      OP_F4: begin a_op = 36'(a2_r); b_op = 33'(y_c); end
      OP_MA: begin
        a_op = pan_mode_r ? 36'(mid) : 36'(side);
        b_op = pan_mode_r ? $signed({16'b0, pgl_r}) : $signed({16'b0, width_now_r});
      end
      OP_MB: begin a_op = t_r; b_op = $signed({8'b0, gain_now_r}); end
      OP_MC: begin
        a_op = pan_mode_r ? 36'(mid) : u_r;
        b_op = pan_mode_r ? $signed({16'b0, pgr_r}) : $signed({8'b0, gain_now_r});
      end
      OP_MD: begin a_op = t_r; b_op = $signed({8'b0, gain_now_r}); end
      default: begin a_op = '0; b_op = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_r       <= B0_RESET;
      b1_r       <= '0;
      b2_r       <= '0;
      a1_r       <= '0;
      a2_r       <= '0;
      pan_mode_r <= 1'b0;
      pgl_r      <= PAN_RESET;
      pgr_r      <= PAN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_B0:       b0_r       <= $signed(cfg_wdata);
        REG_B1:       b1_r       <= $signed(cfg_wdata);
        REG_B2:       b2_r       <= $signed(cfg_wdata);
        REG_A1:       a1_r       <= $signed(cfg_wdata);
        REG_A2:       a2_r       <= $signed(cfg_wdata);
        REG_PAN_MODE: pan_mode_r <= cfg_wdata[0];
        REG_PAN_L:    pgl_r      <= cfg_wdata[16:0];
        REG_PAN_R:    pgr_r      <= cfg_wdata[16:0];
        default:      pan_mode_r <= pan_mode_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      xl_r <= in_left_in;
      xr_r <= in_right_in;
      tg_r <= in_target_gain;
      tw_r <= in_target_width;
    end
    if (cmd.mul) begin
      p_r <= a_op * b_op;
    end
    if (cmd.load_out) begin
      out_l_r <= lo_r;
      out_r_r <= ro_r;
    end
  end

  // consume the product of the current operation
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d0l_r <= '0;
      d1l_r <= '0;
      d0r_r <= '0;
      d1r_r <= '0;
    end else if (cmd.acc) begin
      case (cmd.op)
        OP_F0: begin
          if (cmd.chan) begin
            yr_r <= z[47:17];
          end else begin
            yl_r <= z[47:17];
          end
        end
        OP_F1: s_r <= ph10 + 64'(d1_c);
        OP_F2: begin
          if (cmd.chan) begin
            d0r_r <= sat48(s_r - ph10);
          end else begin
            d0l_r <= sat48(s_r - ph10);
          end
        end
        OP_F3: s_r <= ph10;
        OP_F4: begin
          if (cmd.chan) begin
            d1r_r <= sat48(s_r - ph10);
          end else begin
            d1l_r <= sat48(s_r - ph10);
          end
        end
        OP_MA: begin
          if (pan_mode_r) begin
            t_r <= 36'(ph16);
          end else begin
            t_r <= 36'(64'(mid) + ph15);
            u_r <= 36'(64'(mid) - ph15);
          end
        end
        OP_MB: lo_r <= sat_s(ph20);
        OP_MC: begin
          if (pan_mode_r) begin
            t_r <= 36'(ph16);
          end else begin
            ro_r <= sat_s(ph20);
          end
        end
        OP_MD: ro_r <= sat_s(ph20);
        default: s_r <= s_r;
      endcase
    end
  end

  assign g_sum = $signed({2'b00, gain_now_r}) + $signed({gain_inc_r[25], gain_inc_r});
  assign w_sum = $signed({2'b00, width_now_r}) + $signed({width_inc_r[17], width_inc_r});

  // gain and width ramps: take targets, load increments, advance once per item (width not in pan mode)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_now_r   <= UNITY_GAIN;
      gain_goal_r  <= UNITY_GAIN;
      gain_inc_r   <= '0;
      gain_left_r  <= '0;
      width_now_r  <= '0;
      width_goal_r <= '0;
      width_inc_r  <= '0;
      width_left_r <= '0;
    end else begin
      if (cmd.take_g && gain_new) begin
        gain_goal_r <= {1'b0, tg_r};
        if (GAIN_RAMP_STEPS == 0) begin
          gain_now_r  <= {1'b0, tg_r};
          gain_left_r <= '0;
          gain_inc_r  <= '0;
        end else begin
          gain_left_r <= 12'(GAIN_RAMP_STEPS);
        end
      end
      if (cmd.take_w && width_new) begin
        width_goal_r <= tw_r;
        if (WIDTH_RAMP_STEPS == 0) begin
          width_now_r  <= tw_r;
          width_left_r <= '0;
          width_inc_r  <= '0;
        end else begin
          width_left_r <= 12'(WIDTH_RAMP_STEPS);
        end
      end
      if (cmd.inc_g_load) begin
        gain_inc_r <= gdiv_quot;
      end
      if (cmd.inc_w_load) begin
        width_inc_r <= wdiv_quot;
      end
      if (cmd.adv) begin
        if (gain_left_r == '0) begin
          gain_now_r <= gain_goal_r;
        end else begin
          gain_left_r <= gain_left_r - 1'b1;
          gain_now_r  <= (gain_left_r != 12'd1) ? g_sum[24:0] : gain_goal_r;
        end
        // hold the width ramp in pan mode
        if (!pan_mode_r) begin
          if (width_left_r == '0) begin
            width_now_r <= width_goal_r;
          end else begin
            width_left_r <= width_left_r - 1'b1;
            width_now_r  <= (width_left_r != 12'd1) ? w_sum[16:0] : width_goal_r;
          end
        end
      end
    end
  end

  assign out_left_out  = out_l_r;
  assign out_right_out = out_r_r;

endmodule

`default_nettype wire

// ----- dv/stereo_eq_pan_width_mixer_tb.sv -----
// Testbench for stereo_eq_pan_width_mixer: biquad EQ, width/pan mix, gain ramps.
// Holds its own bit-exact predictor and scoreboard; depends on sepw_pkg and the RTL.
`timescale 1ns / 100ps

module stereo_eq_pan_width_mixer_tb;
  import sepw_pkg::*;

  localparam int GAIN_STEPS  = 2400;
  localparam int WIDTH_STEPS = 960;
  localparam int SETTLE      = 120;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic signed [23:0] left;
    logic signed [23:0] right;
    logic [23:0]        tgain;
    logic [16:0]        twidth;
  } pair_t;

  typedef struct packed {
    logic signed [23:0] left;
    logic signed [23:0] right;
  } mix_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [23:0] in_left_in = '0, in_right_in = '0;
  logic [23:0] in_target_gain = '0;
  logic [16:0] in_target_width = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [23:0] out_left_out, out_right_out;

  stereo_eq_pan_width_mixer dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .in_valid(in_valid), .in_stall(in_stall),
    .in_left_in(in_left_in), .in_right_in(in_right_in),
    .in_target_gain(in_target_gain), .in_target_width(in_target_width),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_left_out(out_left_out), .out_right_out(out_right_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  longint m_b0, m_b1, m_b2, m_a1, m_a2;
  bit m_pan;
  longint m_pl, m_pr;
  longint dl[2], dr[2];
  longint g_now, g_goal, g_inc, g_left;
  longint w_now, w_goal, w_inc, w_left;

  pair_t pending_pairs[$];
  mix_t  expected_mix[$];
  int send_idle_pct = 0, recv_idle_pct = 0;
  bit hold_off = 1'b0;
  int hold_cycles = 0;
  int mismatches = 0;
  int errors = 0;
  longint cycles = 0;
  bit in_taken = 1'b0;

  function automatic longint sat_bits(longint v, int bits);
    longint hi, lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  function automatic longint filter_step(longint x, inout longint d[2]);
    longint z, y, s1, s2;
    z = sat_bits(((m_b0 * x) >>> 10) + d[0], 48);
    y = z >>> 17;
    s1 = ((m_b1 * x) >>> 10) - ((m_a1 * y) >>> 10) + d[1];
    s2 = ((m_b2 * x) >>> 10) - ((m_a2 * y) >>> 10);
    d[0] = sat_bits(s1, 48);
    d[1] = sat_bits(s2, 48);
    return y;
  endfunction

  task automatic take_target(inout longint now, inout longint goal, inout longint inc,
                             inout longint left, input longint t, input longint steps);
    if (t != goal) begin
      goal = t;
      if (steps <= 0) begin
        now = t; left = 0; inc = 0;
      end else begin
        left = steps;
        inc = (t - now) / steps;
      end
    end
  endtask

  task automatic advance(inout longint now, input longint goal, input longint inc,
                         inout longint left);
    if (left == 0) begin
      now = goal;
    end else begin
      left--;
      if (left != 0) now += inc;
      else now = goal;
    end
  endtask

  task automatic predict_mix(input pair_t p);
    longint yl, yr, m, s, ws, l, r;
    mix_t e;
    take_target(g_now, g_goal, g_inc, g_left, longint'(p.tgain), GAIN_STEPS);
    take_target(w_now, w_goal, w_inc, w_left, longint'(p.twidth), WIDTH_STEPS);
    yl = filter_step(longint'(p.left), dl);
    yr = filter_step(longint'(p.right), dr);
    advance(g_now, g_goal, g_inc, g_left);
    m = (yl + yr) >>> 1;
    if (m_pan) begin
      l = (((m * m_pl) >>> 16) * g_now) >>> 20;
      r = (((m * m_pr) >>> 16) * g_now) >>> 20;
    end else begin
      s = (yl - yr) >>> 1;
      advance(w_now, w_goal, w_inc, w_left);
      ws = (s * w_now) >>> 15;
      l = ((m + ws) * g_now) >>> 20;
      r = ((m - ws) * g_now) >>> 20;
    end
    e.left = 24'(sat_bits(l, 24));
    e.right = 24'(sat_bits(r, 24));
    expected_mix.push_back(e);
  endtask

  // mark the input transfer at the edge where it happens
  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && !in_stall;
  end

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_taken) begin
        predict_mix({in_left_in, in_right_in, in_target_gain, in_target_width});
        void'(pending_pairs.pop_front());
      end
      if (!in_valid || in_taken) begin
        if (pending_pairs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_left_in <= pending_pairs[0].left;
          in_right_in <= pending_pairs[0].right;
          in_target_gain <= pending_pairs[0].tgain;
          in_target_width <= pending_pairs[0].twidth;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (expected_mix.size() == 0) begin
        errors++;
        if (mismatches < 10) $display("unexpected result %0d %0d", out_left_out, out_right_out);
        mismatches++;
      end else begin
        mix_t e;
        e = expected_mix.pop_front();
        if (e.left !== out_left_out || e.right !== out_right_out) begin
          errors++;
          if (mismatches < 10)
            $display("mismatch: expected L %0d R %0d, got L %0d R %0d",
                     e.left, e.right, out_left_out, out_right_out);
          mismatches++;
        end
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input longint val);
    longint mask;
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= 32'(val);
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_B0: m_b0 = longint'(signed'(32'(val)));
      REG_B1: m_b1 = longint'(signed'(32'(val)));
      REG_B2: m_b2 = longint'(signed'(32'(val)));
      REG_A1: m_a1 = longint'(signed'(32'(val)));
      REG_A2: m_a2 = longint'(signed'(32'(val)));
      REG_PAN_MODE: m_pan = val[0];
      REG_PAN_L: m_pl = longint'(val[16:0]);
      REG_PAN_R: m_pr = longint'(val[16:0]);
      default: ;
    endcase
  endtask

  // wait until every transfer and result is done, then let the block settle
  task automatic drain();
    while (pending_pairs.size() > 0 || in_valid || expected_mix.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic add_pair(input longint l, input longint r, input longint g, input longint w);
    pair_t p;
    p.left = 24'(l); p.right = 24'(r); p.tgain = 24'(g); p.twidth = 17'(w);
    pending_pairs.push_back(p);
  endtask

  function automatic longint rand_sample();
    case ($urandom_range(5))
      0: return 8388607;
      1: return -8388608;
      2: return longint'($urandom_range(2000)) - 1000;
      default: return longint'(signed'(24'($urandom)));
    endcase
  endfunction

  // mostly keep targets steady so the ramps run long; change now and then
  task automatic add_random(input int n);
    longint g, w;
    g = $urandom_range(24'hFFFFFF);
    w = $urandom_range(65536);
    repeat (n) begin
      if ($urandom_range(19) == 0) g = ($urandom_range(1) ? $urandom_range(24'hFFFFFF)
                                                           : $urandom_range(2097152));
      if ($urandom_range(19) == 0) w = ($urandom_range(3) == 0) ? 17'h1FFFF
                                                                : $urandom_range(65536);
      add_pair(rand_sample(), rand_sample(), g, w);
    end
  endtask

  task automatic random_filter();
    write_reg(REG_B0, $urandom_range(1) ? 134217728 : longint'(signed'($urandom)));
    write_reg(REG_B1, longint'(signed'($urandom)) >>> $urandom_range(4));
    write_reg(REG_B2, longint'(signed'($urandom)) >>> $urandom_range(4));
    write_reg(REG_A1, longint'(signed'($urandom)) >>> $urandom_range(5));
    write_reg(REG_A2, longint'(signed'($urandom)) >>> $urandom_range(5));
  endtask

  initial begin
    m_b0 = 134217728; m_b1 = 0; m_b2 = 0; m_a1 = 0; m_a2 = 0;
    m_pan = 0; m_pl = 46341; m_pr = 46341;
    dl[0] = 0; dl[1] = 0; dr[0] = 0; dr[1] = 0;
    g_now = 1048576; g_goal = 1048576; g_inc = 0; g_left = 0;
    w_now = 0; w_goal = 0; w_inc = 0; w_left = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (SETTLE) @(posedge clk);

    // directed: extremes at reset settings, gain jump, width ramps
    add_pair(8388607, -8388608, 1048576, 0);
    add_pair(-8388608, 8388607, 16777215, 65536);
    add_pair(8388607, 8388607, 16777215, 65536);
    add_pair(0, 0, 0, 65536);
    add_pair(-8388608, -8388608, 16777215, 131071);
    add_pair(1234567, -7654321, 16777215, 131071);
    drain();
    // filter saturation with extreme coefficients
    write_reg(REG_B0, 32'h7FFFFFFF);
    write_reg(REG_B1, -2147483648);
    write_reg(REG_B2, 32'h7FFFFFFF);
    write_reg(REG_A1, -2147483648);
    write_reg(REG_A2, 32'h7FFFFFFF);
    repeat (5) add_pair(8388607, -8388608, 1048576, 32768);
    add_pair(-8388608, 8388607, 1048576, 32768);
    drain();
    // pan mode, gains above 1.0 and zero, width target taken but frozen
    write_reg(REG_PAN_MODE, 1);
    write_reg(REG_PAN_L, 65536);
    write_reg(REG_PAN_R, 0);
    repeat (3) add_pair(8388607, 8388607, 16777215, 0);
    drain();
    write_reg(REG_PAN_L, 131071);
    write_reg(REG_PAN_R, 131071);
    write_reg(REG_B0, 134217728);
    write_reg(REG_B1, 0); write_reg(REG_B2, 0); write_reg(REG_A1, 0); write_reg(REG_A2, 0);
    add_pair(8388607, 8388607, 16777215, 1000);
    add_pair(-8388608, -8388608, 0, 65536);
    add_pair(0, 0, 1048576, 65536);
    drain();
    write_reg(REG_PAN_MODE, 0);

    // random: phase 1, sender idles little, receiver a lot
    send_idle_pct = 14; recv_idle_pct = 83;
    random_filter();
    add_random(180);
    // long receiver hold-off while the sender keeps offering
    hold_cycles = 600;
    drain();
    // sender pause until all results have come, then continue
    add_random(10);
    drain();
    write_reg(REG_PAN_MODE, 1);
    write_reg(REG_PAN_L, $urandom_range(65536));
    write_reg(REG_PAN_R, $urandom_range(131071));
    send_idle_pct = 83; recv_idle_pct = 14;
    random_filter();
    add_random(180);
    drain();
    write_reg(REG_PAN_MODE, 0);
    write_reg(REG_B0, 134217728);
    write_reg(REG_B1, 0); write_reg(REG_B2, 0); write_reg(REG_A1, 0); write_reg(REG_A2, 0);
    send_idle_pct = 0; recv_idle_pct = 0;
    add_random(180);
    drain();

    if (errors == 0 && expected_mix.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- stereo_eq_pan_width_mixer.f -----
src/sepw_pkg.sv
src/sepw_div.sv
src/sepw_ctrl.sv
src/sepw_dp.sv
src/stereo_eq_pan_width_mixer.sv
dv/stereo_eq_pan_width_mixer_tb.sv
